/* sv/spi_master_shift_unit_macros.svh */
// Assertion macros shared by the SPI master shift unit checkers.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SPI_MASTER_SHIFT_UNIT_MACROS_SVH
`define SPI_MASTER_SHIFT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* sv/spims_pkg.sv */
// Shared types and constants of the SPI master shift unit.
// No dependencies; imported by every module of the block.
package spims_pkg;

    localparam int DATA_BITS = 8;
    localparam int DIV_WIDTH = 13;
    localparam int EDGE_W    = $clog2(2 * DATA_BITS + 1);
    localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(2 * DATA_BITS);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_WRITE     = 2'd1,
        KIND_READ      = 2'd2,
        KIND_CLEAR_OVF = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_BAUD   = 2'd0,
        REG_MODE   = 2'd1,
        REG_ENABLE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        kind_t                kind;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 miso;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    typedef struct packed {
        logic        we;
        reg_idx_t    idx;
        logic [31:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [DIV_WIDTH-1:0] baud;
        logic [1:0]           mode;
        logic                 enable;
    } cfg_regs_t;

    typedef struct packed {
        logic       mosi;
        logic       sck;
        logic       busy;
        logic       ovf;
        logic       rx_full;
        logic       tx_full;
        logic [7:0] read_data;
    } result_t;

endpackage

/* sv/spi_master_shift_unit.sv */
// SPI master shift unit, 8 bits MSB first, all four CPOL/CPHA modes. Every
// input word (a tick, a transmit write, a receive read or an overflow clear)
// produces exactly one result word with the flags and line levels after it.
// One word is taken per clock while results are being drained; a result
// passes the front register, the queue and the output register, and the
// output register is what paces the block when the downstream side stalls.
// Registers are to be written over APB only while idle; the block does not enforce it.
module spi_master_shift_unit
    import spims_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] miso_in, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] read_data, [8] tx_buffer_full,
                                   // [9] rx_buffer_full, [10] overflow,
                                   // [11] shifter_busy, [12] sck_out,
                                   // [13] mosi_out, [15:14] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    push_t     push;
    logic      q_ready;
    logic      q_valid;
    item_t     q_item;
    logic      pop;
    cfg_wr_t   cfg;
    cfg_regs_t regs;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && pready;
    assign cfg.idx  = reg_idx_t'(paddr[3:2]);
    assign cfg.data = pwdata;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_BAUD:   prdata = {{(32 - DIV_WIDTH){1'b0}}, regs.baud};
            REG_MODE:   prdata = {30'd0, regs.mode};
            REG_ENABLE: prdata = {31'd0, regs.enable};
            default:    prdata = '0;
        endcase
    end

    spims_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .push     (push)
    );

    spims_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .pop       (pop)
    );

    spims_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .regs     (regs),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/spims_front.sv */
// Front stage: accepts input words, decodes the item kind and registers it.
// Depends on spims_pkg; feeds spims_queue.
module spims_front
    import spims_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        q_ready,
    output push_t       push
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    assign s_tready = !valid_reg || q_ready;

    always_comb
    begin
        valid_next = (s_tvalid && s_tready) || (valid_reg && !q_ready);
        item_next  = item_reg;
        if (s_tvalid && s_tready)
        begin
            item_next.kind    = kind_t'(s_tuser);
            // Payload bits only matter for the kinds that use them.
            item_next.tx_byte = (kind_t'(s_tuser) == KIND_WRITE) ? s_tdata[DATA_BITS-1:0]
                                                                : '0;
            item_next.miso    = (kind_t'(s_tuser) == KIND_TICK) ? s_tdata[DATA_BITS] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign push.valid = valid_reg;
    assign push.item  = item_reg;

endmodule

/* sv/spims_queue.sv */
// Short register queue between the front stage and the shift engine.
// Depends on spims_pkg.
module spims_queue
    import spims_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  in_ready,
    output logic  out_valid,
    output item_t out_item,
    input  logic  pop
);

    item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        priority if (do_push && !do_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

/* sv/spims_back.sv */
// Shift engine: holds the configuration, the buffers and the SPI line state,
// executes one queued item per cycle while its result word is not stalled
// and registers that result. Depends on spims_pkg; fed by spims_queue.
module spims_back
    import spims_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_wr_t     cfg,
    output cfg_regs_t   regs,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    logic [DIV_WIDTH-1:0] baud_reg,     baud_next;
    logic [1:0]           mode_reg,     mode_next;
    logic                 enable_reg,   enable_next;
    logic [DATA_BITS-1:0] shift_reg,    shift_next;
    logic [DATA_BITS-1:0] tx_hold_reg,  tx_hold_next;
    logic [DATA_BITS-1:0] rx_hold_reg,  rx_hold_next;
    logic                 tx_full_reg,  tx_full_next;
    logic                 rx_full_reg,  rx_full_next;
    logic                 ovf_reg,      ovf_next;
    logic                 shifting_reg, shifting_next;
    logic [EDGE_W-1:0]    edge_reg,     edge_next;
    logic [DIV_WIDTH-1:0] div_reg,      div_next;
    logic                 sck_reg,      sck_next;
    logic                 mosi_reg,     mosi_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg,      res_next;
    logic [EDGE_W-1:0]    edge_inc;
    logic [DATA_BITS-1:0] read_byte;
    logic                 cpol;
    logic                 cpha;

    assign cpol = mode_reg[1];
    assign cpha = mode_reg[0];
    assign pop  = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        baud_next     = baud_reg;
        mode_next     = mode_reg;
        enable_next   = enable_reg;
        shift_next    = shift_reg;
        tx_hold_next  = tx_hold_reg;
        rx_hold_next  = rx_hold_reg;
        tx_full_next  = tx_full_reg;
        rx_full_next  = rx_full_reg;
        ovf_next      = ovf_reg;
        shifting_next = shifting_reg;
        edge_next     = edge_reg;
        div_next      = div_reg;
        sck_next      = sck_reg;
        mosi_next     = mosi_reg;
        edge_inc      = EDGE_W'(edge_reg + 1'b1);
        read_byte     = '0;

        if (cfg.we)
        begin
            case (cfg.idx)
                REG_BAUD:
                begin
                    baud_next = cfg.data[DIV_WIDTH-1:0];
                end
                REG_MODE:
                begin
                    mode_next = cfg.data[1:0];
                    // Mid-byte, SCK follows the new polarity and the edge parity.
                    sck_next  = shifting_reg ? (cfg.data[1] ^ edge_reg[0]) : cfg.data[1];
                end
                REG_ENABLE:
                begin
                    enable_next = cfg.data[0];
                    if (!cfg.data[0])
                    begin
                        shifting_next = 1'b0;
                        edge_next     = '0;
                        div_next      = '0;
                        sck_next      = cpol;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (pop)
        begin
            unique case (q_item.kind)
                KIND_TICK:
                begin
                    priority if (!enable_reg)
                    begin
                        sck_next = cpol;
                    end
                    else if (!shifting_reg)
                    begin
                        sck_next = cpol;
                        if (tx_full_reg)
                        begin
                            shift_next    = tx_hold_reg;
                            tx_full_next  = 1'b0;
                            shifting_next = 1'b1;
                            edge_next     = '0;
                            div_next      = '0;
                            if (!cpha)
                            begin
                                mosi_next = tx_hold_reg[DATA_BITS-1];
                            end
                        end
                    end
                    else if (div_reg >= baud_reg)
                    begin
                        div_next = '0;
                        sck_next = ~sck_reg;
                        // An edge samples when its parity differs from CPHA.
                        if (edge_inc[0] != cpha)
                        begin
                            shift_next = {shift_reg[DATA_BITS-2:0], q_item.miso};
                        end
                        else if (edge_inc < LAST_EDGE)
                        begin
                            mosi_next = shift_reg[DATA_BITS-1];
                        end
                        if (edge_inc >= LAST_EDGE)
                        begin
                            if (rx_full_reg)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                rx_hold_next = shift_next;
                                rx_full_next = 1'b1;
                            end
                            shifting_next = 1'b0;
                            edge_next     = '0;
                            sck_next      = cpol;
                        end
                        else
                        begin
                            edge_next = edge_inc;
                        end
                    end
                    else
                    begin
                        div_next = DIV_WIDTH'(div_reg + 1'b1);
                    end
                end
                KIND_WRITE:
                begin
                    if (!tx_full_reg)
                    begin
                        tx_hold_next = q_item.tx_byte;
                        tx_full_next = 1'b1;
                    end
                end
                KIND_READ:
                begin
                    read_byte    = rx_hold_reg;
                    rx_full_next = 1'b0;
                end
                KIND_CLEAR_OVF:
                begin
                    ovf_next = 1'b0;
                end
            endcase
        end

        res_next.read_data = read_byte;
        res_next.tx_full   = tx_full_next;
        res_next.rx_full   = rx_full_next;
        res_next.ovf       = ovf_next;
        res_next.busy      = shifting_next;
        res_next.sck       = sck_next;
        res_next.mosi      = mosi_next;
        out_valid_next     = pop || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reg      <= '0;
            mode_reg      <= '0;
            enable_reg    <= 1'b0;
            shift_reg     <= '0;
            tx_hold_reg   <= '0;
            rx_hold_reg   <= '0;
            tx_full_reg   <= 1'b0;
            rx_full_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            shifting_reg  <= 1'b0;
            edge_reg      <= '0;
            div_reg       <= '0;
            sck_reg       <= 1'b0;
            mosi_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            baud_reg      <= baud_next;
            mode_reg      <= mode_next;
            enable_reg    <= enable_next;
            shift_reg     <= shift_next;
            tx_hold_reg   <= tx_hold_next;
            rx_hold_reg   <= rx_hold_next;
            tx_full_reg   <= tx_full_next;
            rx_full_reg   <= rx_full_next;
            ovf_reg       <= ovf_next;
            shifting_reg  <= shifting_next;
            edge_reg      <= edge_next;
            div_reg       <= div_next;
            sck_reg       <= sck_next;
            mosi_reg      <= mosi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign regs.baud   = baud_reg;
    assign regs.mode   = mode_reg;
    assign regs.enable = enable_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {2'b00, res_reg};

endmodule

/* sv/spims_checker.sv */
// Port-level checks of the SPI master shift unit, bound to the top level.
// Depends on spims_pkg and spi_master_shift_unit_macros.svh.
`include "spi_master_shift_unit_macros.svh"

module spims_checker
    import spims_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic        pready
);

    logic cpol_reg;

    // Shadow of the clock polarity, tracked from completed register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpol_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready &&
                 (reg_idx_t'(paddr[3:2]) == REG_MODE))
        begin
            cpol_reg <= pwdata[1];
        end
    end

    // A stalled result word must hold.
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input back-pressure only comes from a result that is waiting.
    `ASSERT_IMPLY(a_stall_has_cause, !s_tready, m_tvalid)

    // With the shifter idle, SCK sits at the configured polarity.
    `ASSERT_IMPLY(a_idle_sck, m_tvalid && !m_tdata[11], m_tdata[12] == cpol_reg)

endmodule

bind spi_master_shift_unit spims_checker u_spims_checker (.*);
